[hdl/divided_slot_bitmap_allocator_defines.svh]
// Assertion helpers for the slot allocator.
// Each expects clk_i and rst_ni in scope at the point of use.
`ifndef DIVIDED_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define DIVIDED_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSBA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dsba_pkg.sv]
`default_nettype none
package dsba_pkg;

  localparam int NUM_DIVISIONS    = 8;
  localparam int DIVISION_SLOTS   = 64;
  localparam int EXTRA_LAST_SLOTS = 2;
  localparam int TOTAL_SLOTS      = NUM_DIVISIONS * DIVISION_SLOTS + EXTRA_LAST_SLOTS;

  // port width of a slot number
  localparam int SLOT_W  = 10;
  // internal slot number width
  localparam int INT_W   = $clog2(TOTAL_SLOTS + 1);
  localparam int CNT_W   = $clog2(DIVISION_SLOTS + EXTRA_LAST_SLOTS + 1);
  localparam int DIV_W   = (NUM_DIVISIONS > 1) ? $clog2(NUM_DIVISIONS) : 1;

  // bitmap storage: one word holds WORD_W used bits
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (TOTAL_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  // number of slots in division d
  function automatic logic [CNT_W-1:0] division_span(input logic [DIV_W-1:0] d);
    logic [CNT_W-1:0] span;
    span = CNT_W'(DIVISION_SLOTS);
    if (d == DIV_W'(NUM_DIVISIONS - 1)) begin
      span = CNT_W'(DIVISION_SLOTS + EXTRA_LAST_SLOTS);
    end
    return span;
  endfunction

endpackage
`default_nettype wire

[hdl/divided_slot_bitmap_allocator.sv]
`default_nettype none
// Backing-store slot allocator with a used-bit bitmap and per-division free counts.
//
// Command channel: drive mode_i/slot_index_i with start high; the word is taken
// on the rising edge where busy is low. mode_i=0 allocates, mode_i=1 releases
// slot_index_i. Every command yields exactly one result word on slot_out_o,
// status_o and writer_wake_o, shown for one cycle while done_o is high. The
// receiver cannot stall: sample the result in that cycle or lose it.
//
// Allocate: a scan walks the eight division counts through one compare unit,
// one count per cycle; if a count is non-zero, the bitmap RAM is then read one
// 32-bit word per cycle until a free bit turns up in the chosen division or its
// words run out (at most two words, three for the last division). The next start
// is taken in the done cycle. The count scan and the single RAM read port set the
// cost of an allocate.
// Release: one RAM read, then the update; a slot that is already free is reported
// with ST_DOUBLE and left as it is. An out-of-range release shows done_o right
// after the accept edge, without touching the RAM.
//
// Reset clears the row-valid flags (every slot reads free at once) and loads
// the division counts; no clearing pass is needed, a start may follow at once.
`include "divided_slot_bitmap_allocator_defines.svh"
module divided_slot_bitmap_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [dsba_pkg::SLOT_W-1:0] slot_index_i,
  output logic                        done_o,
  output logic [dsba_pkg::SLOT_W-1:0] slot_out_o,
  output logic [1:0]                  status_o,
  output logic                        writer_wake_o
);
  import dsba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACHK,
    S_RCHK
  } state_e;

  state_e               state_q, state_d;
  logic [INT_W-1:0]     idx_q, idx_d;
  logic [DIV_W-1:0]     scan_q, scan_d;
  logic [DIV_W-1:0]     best_div_q, best_div_d;
  logic [CNT_W-1:0]     best_cnt_q, best_cnt_d;
  logic [INT_W-1:0]     first_q, first_d;
  logic [INT_W-1:0]     last_q, last_d;
  logic [WADDR_W-1:0]   waddr_q, waddr_d;
  logic [CNT_W-1:0]     count_q [NUM_DIVISIONS];
  logic [CNT_W-1:0]     count_d [NUM_DIVISIONS];
  logic                 row_valid_q [NUM_WORDS];
  logic                 rvalid_q;
  logic                 done_q, done_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  status_e              status_q, status_d;
  logic                 wake_q, wake_d;

  // bitmap RAM
  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [WORD_W-1:0]    rdata_q;
  logic                 mem_we;
  logic [WORD_W-1:0]    mem_wdata;

  // shared datapath
  logic [CNT_W-1:0]     cnt_rd;
  logic                 take;
  logic [DIV_W-1:0]     pick_div;
  logic [CNT_W-1:0]     pick_cnt;
  logic [INT_W-1:0]     pick_first;
  logic [WORD_W-1:0]    word_eff;
  logic [BIT_W-1:0]     lo_bit, hi_bit;
  logic [WORD_W-1:0]    bit_mask, free_bits;
  logic                 found;
  logic [BIT_W-1:0]     found_bit;
  logic [DIV_W-1:0]     rel_div;

  assign cnt_rd     = count_q[scan_q];
  assign take       = (best_cnt_q <= cnt_rd);
  assign pick_div   = take ? scan_q : best_div_q;
  assign pick_cnt   = take ? cnt_rd : best_cnt_q;
  assign pick_first = INT_W'(32'(pick_div) * DIVISION_SLOTS);
  assign word_eff   = rvalid_q ? rdata_q : '0;

  // lowest free bit of the current word, inside the chosen division
  always_comb begin
    lo_bit = '0;
    hi_bit = '1;
    if (waddr_q == WADDR_W'(first_q >> BIT_W)) begin
      lo_bit = first_q[BIT_W-1:0];
    end
    if (waddr_q == WADDR_W'(last_q >> BIT_W)) begin
      hi_bit = last_q[BIT_W-1:0];
    end
    for (int p = 0; p < WORD_W; p++) begin
      bit_mask[p] = (BIT_W'(p) >= lo_bit) && (BIT_W'(p) <= hi_bit);
    end
    free_bits = ~word_eff & bit_mask;
    found     = 1'b0;
    found_bit = '0;
    for (int p = WORD_W - 1; p >= 0; p--) begin
      if (free_bits[p]) begin
        found     = 1'b1;
        found_bit = BIT_W'(p);
      end
    end
  end

  // division of a released slot; the extra slots land in the last one
  always_comb begin
    rel_div = '0;
    for (int d = 1; d < NUM_DIVISIONS; d++) begin
      if (32'(idx_q) >= 32'(d * DIVISION_SLOTS)) begin
        rel_div = DIV_W'(d);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    scan_d     = scan_q;
    best_div_d = best_div_q;
    best_cnt_d = best_cnt_q;
    first_d    = first_q;
    last_d     = last_q;
    waddr_d    = waddr_q;
    count_d    = count_q;
    done_d     = 1'b0;
    slot_d     = slot_q;
    status_d   = status_q;
    wake_d     = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = word_eff;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (!mode_i) begin
            // allocate: walk the counts first
            scan_d     = '0;
            best_div_d = '0;
            best_cnt_d = '0;
            state_d    = S_SCAN;
          end else if (32'(slot_index_i) >= 32'(TOTAL_SLOTS)) begin
            done_d   = 1'b1;
            slot_d   = '0;
            status_d = ST_RANGE;
          end else begin
            idx_d   = INT_W'(slot_index_i);
            waddr_d = WADDR_W'(slot_index_i >> BIT_W);
            state_d = S_RCHK;
          end
        end
      end

      S_SCAN: begin
        best_div_d = pick_div;
        best_cnt_d = pick_cnt;
        scan_d     = scan_q + DIV_W'(1);
        if (scan_q == DIV_W'(NUM_DIVISIONS - 1)) begin
          if (pick_cnt == '0) begin
            done_d   = 1'b1;
            slot_d   = '0;
            status_d = ST_NONE;
            state_d  = S_IDLE;
          end else begin
            first_d = pick_first;
            last_d  = pick_first + INT_W'(division_span(pick_div)) - INT_W'(1);
            waddr_d = WADDR_W'(pick_first >> BIT_W);
            state_d = S_ACHK;
          end
        end
      end

      S_ACHK: begin
        if (found) begin
          mem_we     = 1'b1;
          mem_wdata  = word_eff | (WORD_W'(1) << found_bit);
          count_d[best_div_q] = count_q[best_div_q] - CNT_W'(1);
          done_d     = 1'b1;
          slot_d     = SLOT_W'(INT_W'({waddr_q, found_bit}));
          status_d   = ST_OK;
          state_d    = S_IDLE;
        end else if (waddr_q == WADDR_W'(last_q >> BIT_W)) begin
          // count claimed a free slot the bitmap does not have
          done_d   = 1'b1;
          slot_d   = '0;
          status_d = ST_NONE;
          state_d  = S_IDLE;
        end else begin
          waddr_d = waddr_q + WADDR_W'(1);
        end
      end

      S_RCHK: begin
        done_d  = 1'b1;
        slot_d  = '0;
        state_d = S_IDLE;
        if (!word_eff[idx_q[BIT_W-1:0]]) begin
          status_d = ST_DOUBLE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = word_eff & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
          count_d[rel_div] = count_q[rel_div] + CNT_W'(1);
          status_d  = ST_OK;
          wake_d    = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      scan_q     <= '0;
      best_div_q <= '0;
      best_cnt_q <= '0;
      first_q    <= '0;
      last_q     <= '0;
      waddr_q    <= '0;
      rvalid_q   <= 1'b0;
      done_q     <= 1'b0;
      slot_q     <= '0;
      status_q   <= ST_OK;
      wake_q     <= 1'b0;
      for (int d = 0; d < NUM_DIVISIONS; d++) begin
        count_q[d] <= division_span(DIV_W'(d));
      end
      for (int w = 0; w < NUM_WORDS; w++) begin
        row_valid_q[w] <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      scan_q     <= scan_d;
      best_div_q <= best_div_d;
      best_cnt_q <= best_cnt_d;
      first_q    <= first_d;
      last_q     <= last_d;
      waddr_q    <= waddr_d;
      rvalid_q   <= row_valid_q[waddr_d];
      done_q     <= done_d;
      slot_q     <= slot_d;
      status_q   <= status_d;
      wake_q     <= wake_d;
      count_q    <= count_d;
      if (mem_we) begin
        row_valid_q[waddr_q] <= 1'b1;
      end
    end
  end

  // write at the current word, read the next word address
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr_q] <= mem_wdata;
    end
    rdata_q <= mem[waddr_d];
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign slot_out_o    = slot_q;
  assign status_o      = status_q;
  assign writer_wake_o = wake_q;

  `DSBA_ASSERT_NOW(a_wake_only_ok, done_o && writer_wake_o, status_o == ST_OK && slot_out_o == '0, "wake on a failed release")
  `DSBA_ASSERT_NOW(a_fail_zero_slot, done_o && status_o != ST_OK, slot_out_o == '0 && !writer_wake_o, "failed word carries a slot")
  `DSBA_ASSERT_NOW(a_done_idle, done_o, !busy, "result shown while busy")
  `DSBA_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done_o, "accepted command went nowhere")

endmodule
`default_nettype wire
